// ----- sv/ctok_pkg.sv -----
package ctok_pkg;

   // most results one input transaction can cause (closing a block comment)
   localparam int ResultsMax = 3;
   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   typedef struct packed {
      logic [7:0] in_char;
      logic       end_of_input;
   } ctok_req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       token_last;
   } ctok_rsp_type;

   typedef struct packed {
      logic [1:0]                        count;
      ctok_rsp_type [ResultsMax-1:0]     item;
   } ctok_push_type;

   localparam logic [7:0] CharHash      = 8'h23;
   localparam logic [7:0] CharBackslash = 8'h5C;
   localparam logic [7:0] CharDquote    = 8'h22;
   localparam logic [7:0] CharSquote    = 8'h27;
   localparam logic [7:0] CharSlash     = 8'h2F;
   localparam logic [7:0] CharStar      = 8'h2A;
   localparam logic [7:0] CharEqual     = 8'h3D;
   localparam logic [7:0] CharGreater   = 8'h3E;
   localparam logic [7:0] CharMinus     = 8'h2D;
   localparam logic [7:0] CharNewline   = 8'h0A;
   localparam logic [7:0] CharSpace     = 8'h20;
   localparam logic [7:0] CharTab       = 8'h09;
   localparam logic [7:0] CharReturn    = 8'h0D;

endpackage

// ----- sv/ctok_lexer.sv -----
module ctok_lexer import ctok_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  ctok_req_type  req,
   output ctok_push_type push
);

   typedef enum logic [2:0] {
      MODE_NORMAL,
      MODE_STRING,
      MODE_PREPROC,
      MODE_LINE_COMMENT,
      MODE_BLOCK_COMMENT,
      MODE_OP_WAIT,
      MODE_SLASH_WAIT
   } mode_type;

   typedef struct packed {
      mode_type                  mode;
      logic [7:0]                pend_char;
      logic                      pend_valid;
      logic [7:0]                prev_char;
      logic [7:0]                quote_char;
      logic                      esc_odd;
      logic [1:0]                cnt;
      ctok_rsp_type [ResultsMax-1:0] res;
   } work_type;

   mode_type   mode_ff, mode_in;
   logic [7:0] pend_char_ff, pend_char_in;
   logic       pend_valid_ff, pend_valid_in;
   logic [7:0] prev_char_ff, prev_char_in;
   logic [7:0] quote_char_ff, quote_char_in;
   logic       esc_odd_ff, esc_odd_in;
   work_type   w;

   function automatic work_type put_char(work_type wi, logic [7:0] c, logic last);
      work_type wo;
      wo = wi;
      wo.res[wi.cnt].out_char   = c;
      wo.res[wi.cnt].token_last = last;
      wo.cnt = wi.cnt + 2'd1;
      return wo;
   endfunction

   function automatic work_type append_char(work_type wi, logic [7:0] c);
      work_type wo;
      wo = wi;
      if (wi.pend_valid) begin
         wo = put_char(wo, wi.pend_char, 1'b0);
      end
      wo.pend_char  = c;
      wo.pend_valid = 1'b1;
      return wo;
   endfunction

   function automatic work_type end_token(work_type wi);
      work_type wo;
      wo = wi;
      if (wi.pend_valid) begin
         wo = put_char(wo, wi.pend_char, 1'b1);
      end
      wo.pend_valid = 1'b0;
      return wo;
   endfunction

   function automatic work_type normal_char(work_type wi, logic [7:0] c);
      work_type wo;
      wo = wi;
      wo.mode = MODE_NORMAL;
      if (c inside {CharSpace, CharNewline, CharTab, CharReturn}) begin
         wo = end_token(wo);
      end else if (c inside {8'h2C, 8'h3B, 8'h28, 8'h29, 8'h7B, 8'h7D, 8'h5B, 8'h5D}) begin
         wo = end_token(wo);
         wo = put_char(wo, c, 1'b1);
      end else if (c inside {8'h2B, CharMinus, CharStar, 8'h25, CharGreater, 8'h3C,
                             8'h21, CharEqual, 8'h26, 8'h7C}) begin
         wo = end_token(wo);
         wo = append_char(wo, c);
         wo.mode = MODE_OP_WAIT;
      end else if (c == CharSlash) begin
         wo = end_token(wo);
         wo = append_char(wo, c);
         wo.mode = MODE_SLASH_WAIT;
      end else if (c == CharHash) begin
         wo = end_token(wo);
         wo = append_char(wo, c);
         wo.mode = MODE_PREPROC;
      end else if (c == CharDquote || c == CharSquote) begin
         wo = append_char(wo, c);
         wo.quote_char = c;
         wo.esc_odd    = 1'b0;
         wo.mode       = MODE_STRING;
      end else begin
         wo = append_char(wo, c);
      end
      return wo;
   endfunction

   always_comb begin
      logic [7:0] c;
      c = req.in_char;
      w = '0;
      w.mode       = mode_ff;
      w.pend_char  = pend_char_ff;
      w.pend_valid = pend_valid_ff;
      w.prev_char  = prev_char_ff;
      w.quote_char = quote_char_ff;
      w.esc_odd    = esc_odd_ff;
      if (req.end_of_input) begin
         w = end_token(w);
         w.mode       = MODE_NORMAL;
         w.pend_char  = 8'd0;
         w.prev_char  = 8'd0;
         w.quote_char = 8'd0;
         w.esc_odd    = 1'b0;
      end else begin
         unique case (mode_ff)
            MODE_STRING: begin
               w = append_char(w, c);
               if (c == quote_char_ff && !esc_odd_ff) begin
                  w.mode = MODE_NORMAL;
               end else if (c == CharBackslash) begin
                  w.esc_odd = ~esc_odd_ff;
               end else begin
                  w.esc_odd = 1'b0;
               end
            end
            MODE_PREPROC, MODE_LINE_COMMENT: begin
               w = append_char(w, c);
               if (c == CharNewline) begin
                  w = end_token(w);
                  w.mode = MODE_NORMAL;
               end
            end
            MODE_BLOCK_COMMENT: begin
               w = append_char(w, c);
               if (prev_char_ff == CharStar && c == CharSlash) begin
                  w = append_char(w, CharNewline);
                  w = end_token(w);
                  w.prev_char = 8'd0;
                  w.mode      = MODE_NORMAL;
               end else begin
                  w.prev_char = c;
               end
            end
            MODE_OP_WAIT: begin
               if (c == CharEqual || c == pend_char_ff ||
                   (pend_char_ff == CharMinus && c == CharGreater)) begin
                  w = append_char(w, c);
                  w = end_token(w);
                  w.mode = MODE_NORMAL;
               end else begin
                  w = end_token(w);
                  w = normal_char(w, c);
               end
            end
            MODE_SLASH_WAIT: begin
               if (c == CharSlash) begin
                  w = append_char(w, c);
                  w.mode = MODE_LINE_COMMENT;
               end else if (c == CharStar) begin
                  w = append_char(w, c);
                  w.prev_char = 8'd0;
                  w.mode      = MODE_BLOCK_COMMENT;
               end else if (c == CharEqual) begin
                  w = append_char(w, c);
                  w = end_token(w);
                  w.mode = MODE_NORMAL;
               end else begin
                  w = end_token(w);
                  w = normal_char(w, c);
               end
            end
            default: begin
               w = normal_char(w, c);
            end
         endcase
      end
   end

   always_comb begin
      mode_in       = mode_ff;
      pend_char_in  = pend_char_ff;
      pend_valid_in = pend_valid_ff;
      prev_char_in  = prev_char_ff;
      quote_char_in = quote_char_ff;
      esc_odd_in    = esc_odd_ff;
      if (accept) begin
         mode_in       = w.mode;
         pend_char_in  = w.pend_char;
         pend_valid_in = w.pend_valid;
         prev_char_in  = w.prev_char;
         quote_char_in = w.quote_char;
         esc_odd_in    = w.esc_odd;
      end
   end

   assign push.count = accept ? w.cnt : 2'd0;
   assign push.item  = w.res;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_NORMAL;
         pend_char_ff  <= 8'd0;
         pend_valid_ff <= 1'b0;
         prev_char_ff  <= 8'd0;
         quote_char_ff <= 8'd0;
         esc_odd_ff    <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         pend_char_ff  <= pend_char_in;
         pend_valid_ff <= pend_valid_in;
         prev_char_ff  <= prev_char_in;
         quote_char_ff <= quote_char_in;
         esc_odd_ff    <= esc_odd_in;
      end
   end

endmodule

// ----- sv/ctok_fifo.sv -----
module ctok_fifo import ctok_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  ctok_push_type push,
   output logic          space_ok,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output ctok_rsp_type  rsp_payload
);

   ctok_rsp_type            mem_ff [QueueDepth];
   logic [QueuePtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0]    count_ff, count_in;
   logic                    pop;

   // room for the largest burst of one transaction
   assign space_ok    = count_ff <= QueueCntW'(QueueDepth - ResultsMax);
   assign rsp_valid   = count_ff != '0;
   assign rsp_payload = mem_ff[rd_ptr_ff];
   assign pop         = rsp_valid && !rsp_stall;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QueuePtrW'(push.count);
      rd_ptr_in = rd_ptr_ff + QueuePtrW'(pop);
      count_in  = count_ff + QueueCntW'(push.count) - QueueCntW'(pop);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ResultsMax; i++) begin
         if (2'(i) < push.count) begin
            mem_ff[wr_ptr_ff + QueuePtrW'(i)] <= push.item[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- sv/c_source_tokenizer.sv -----
// a released token character is written into the result queue and leaves from its registered head
// throughput: one input transaction per cycle while the result queue holds at most one entry
// a transaction yields zero to three results, drained one per cycle while rsp_stall is low through a four-entry queue
// reset: synchronous, active high; lexer back to normal mode, nothing pending, queue empty
module c_source_tokenizer import ctok_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  ctok_req_type req_payload,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output ctok_rsp_type rsp_payload
);

   ctok_push_type push;
   logic          space_ok;
   logic          accept;

   // stall comes from queue occupancy only, no path from rsp_stall
   assign req_stall = !space_ok;
   assign accept    = req_valid && !req_stall;

   // lexer state plus next-state logic; emits up to three token characters
   ctok_lexer u_lexer (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_payload),
      .push   (push)
   );

   // result queue decouples the burst from the output handshake
   ctok_fifo u_fifo (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .space_ok    (space_ok),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// ----- sv/ctok_checker.sv -----
module ctok_checker import ctok_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input ctok_req_type req_payload,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input ctok_rsp_type rsp_payload
);

   // queue comes out of reset empty and open
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("output not empty after reset");

   // a result only appears after an accepted transaction
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall))
      else $error("result without a preceding input transaction");

   // input is only held off while results are queued
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with an empty queue");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

endmodule

bind c_source_tokenizer ctok_checker u_ctok_checker (.*);
